### hw/rtl/bounded_set_span_tracker_macros.svh
// ---------------------------------------------------------------------------
// bounded_set_span_tracker assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_MACROS_SVH
`define BOUNDED_SET_SPAN_TRACKER_MACROS_SVH

// same-cycle implication
`define BSST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BSST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bsst_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsst_pkg
// Widths, constants and types shared by the span tracker files.
// ---------------------------------------------------------------------------
package bsst_pkg;

    localparam int VAL_W     = 32;
    localparam int GAP_W     = 33;
    localparam int ALU_W     = 34;
    localparam int CNT_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [GAP_W-1:0] GAP_ONES  = '1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_INS,
        ST_GAP_A,
        ST_DIFF_B,
        ST_GAP_B,
        ST_LO,
        ST_HI,
        ST_SPAN,
        ST_OUT
    } state_t;

    // shared subtractor result
    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             neg;
    } alu_res_t;

endpackage

### hw/rtl/bsst_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsst_in_if
// Input channel: one value per transfer plus a start-new flag.
// ---------------------------------------------------------------------------
interface bsst_in_if import bsst_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    start_new;

    modport source (output valid, output value, output start_new, input ready);
    modport sink   (input valid, input value, input start_new, output ready);

endinterface

### hw/rtl/bsst_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsst_out_if
// Result channel: spans, flags and count for one input transfer.
// ---------------------------------------------------------------------------
interface bsst_out_if import bsst_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] shortest_span;
    logic [VAL_W-1:0] longest_span;
    logic             span_valid;
    logic             full_error;
    logic [CNT_W-1:0] stored_count;

    modport source (
        output valid, output shortest_span, output longest_span,
        output span_valid, output full_error, output stored_count,
        input ready
    );
    modport sink (
        input valid, input shortest_span, input longest_span,
        input span_valid, input full_error, input stored_count,
        output ready
    );

endinterface

### hw/rtl/bsst_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsst_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module bsst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bsst_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsst_alu
// Shared signed subtractor used for ordering, gap and span arithmetic.
// ---------------------------------------------------------------------------
module bsst_alu import bsst_pkg::*; (
    input  logic signed [ALU_W-1:0] op_a,
    input  logic signed [ALU_W-1:0] op_b,
    output alu_res_t                res
);

    logic signed [ALU_W-1:0] diff;

    // operands are sign or zero extended by the caller, so no overflow
    assign diff     = op_a - op_b;
    assign res.diff = diff;
    assign res.neg  = diff[ALU_W-1];

endmodule

### hw/rtl/bounded_set_span_tracker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_set_span_tracker
// Sorted bounded set of signed values reporting minimum gap and range.
// ---------------------------------------------------------------------------
// Usage:
//   item channel carries value and start_new; result channel returns one
//   result per accepted item (spans, span_valid, full_error, stored_count).
//   cfg_we/cfg_wdata write the capacity register; write only while idle.
// Insertion: an accepted value is inserted by scanning the sorted RAM from the
//   top down, reading each entry visited, then comparing it and shifting it
//   up one slot if it lies above the new value; the scan stops at the first
//   entry not above it. The gap, range and span steps then run before the
//   result is loaded. A rejected (full) item skips straight to the span step.
// Throughput: one item at a time; item.ready is high only while idle. The
//   single RAM port pair and the shared subtractor set the per-entry cost.
// Reset: the set is empty, the minimum gap is all ones and capacity is 64.
//   No clearing pass is needed since only filled entries are ever read.
// Stall: a finished result sits in the output register until taken; the
//   next item may be accepted meanwhile but its result waits for that slot.
// ---------------------------------------------------------------------------
module bounded_set_span_tracker import bsst_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bsst_in_if.sink           item,
    bsst_out_if.source        result,
    input  logic              cfg_we,
    input  logic [CNT_W-1:0]  cfg_wdata
);

`include "bounded_set_span_tracker_macros.svh"

    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT =
        (DEPTH < (1 << CNT_W)) ? CNT_W'(DEPTH) : '1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         capacity_reg;
    logic signed [VAL_W-1:0]  x_reg, x_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [GAP_W-1:0]         gap_reg, gap_next;
    logic [GAP_W-1:0]         cand_reg, cand_next;
    logic signed [VAL_W-1:0]  lo_reg, lo_next;
    logic signed [VAL_W-1:0]  hi_reg, hi_next;
    logic signed [VAL_W-1:0]  b_reg, b_next;
    logic                     have_a_reg, have_a_next;
    logic                     have_b_reg, have_b_next;
    logic                     full_reg, full_next;
    logic [VAL_W-1:0]         span_reg, span_next;

    logic                     out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]         out_short_reg, out_short_next;
    logic [VAL_W-1:0]         out_long_reg, out_long_next;
    logic                     out_sv_reg, out_sv_next;
    logic                     out_full_reg, out_full_next;
    logic [CNT_W-1:0]         out_cnt_reg, out_cnt_next;

    logic [CNT_W-1:0]         limit;
    logic [CNT_W-1:0]         cnt_eff;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [VAL_W-1:0]         ram_wdata;
    logic [VAL_W-1:0]         ram_rdata;
    logic signed [ALU_W-1:0]  op_a, op_b;
    alu_res_t                 alu_res;
    logic                     in_fire;
    logic                     span_ok;

    // sorted value store
    bsst_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // shared subtractor
    bsst_alu u_alu (
        .op_a (op_a),
        .op_b (op_b),
        .res  (alu_res)
    );

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // effective capacity saturates at the store depth
    assign limit   = (capacity_reg > DEPTH_CNT) ? DEPTH_CNT : capacity_reg;
    assign in_fire = item.valid && item.ready;
    assign cnt_eff = item.start_new ? '0 : cnt_reg;
    assign span_ok = cnt_reg >= CNT_W'(2);

    assign item.ready = (state_reg == ST_IDLE);

    // subtractor operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_CMP:
            begin
                op_a = ALU_W'(x_reg);
                op_b = ALU_W'($signed(ram_rdata));
            end
            ST_GAP_A, ST_GAP_B:
            begin
                op_a = ALU_W'({1'b0, cand_reg});
                op_b = ALU_W'({1'b0, gap_reg});
            end
            ST_DIFF_B:
            begin
                op_a = ALU_W'(b_reg);
                op_b = ALU_W'(x_reg);
            end
            ST_LO:
            begin
                op_a = ALU_W'(x_reg);
                op_b = ALU_W'(lo_reg);
            end
            ST_HI:
            begin
                op_a = ALU_W'(hi_reg);
                op_b = ALU_W'(x_reg);
            end
            ST_SPAN:
            begin
                op_a = ALU_W'(hi_reg);
                op_b = ALU_W'(lo_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // sequencer: next state, datapath updates and RAM control
    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        gap_next       = gap_reg;
        cand_next      = cand_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        b_next         = b_reg;
        have_a_next    = have_a_reg;
        have_b_next    = have_b_reg;
        full_next      = full_reg;
        span_next      = span_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_short_next = out_short_reg;
        out_long_next  = out_long_reg;
        out_sv_next    = out_sv_reg;
        out_full_next  = out_full_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = x_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next      = item.value;
                    cnt_next    = cnt_eff;
                    have_a_next = 1'b0;
                    have_b_next = 1'b0;
                    full_next   = cnt_eff >= limit;
                    if (item.start_new)
                    begin
                        gap_next = GAP_ONES;
                    end
                    priority if (cnt_eff >= limit)
                    begin
                        state_next = ST_SPAN;
                    end
                    else if (cnt_eff == '0)
                    begin
                        idx_next   = '0;
                        state_next = ST_INS;
                    end
                    else
                    begin
                        idx_next   = ADDR_W'(cnt_eff - CNT_W'(1));
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (alu_res.neg)
                begin
                    // stored entry above the new value: shift it up one slot
                    ram_we      = 1'b1;
                    ram_waddr   = idx_reg + ADDR_W'(1);
                    ram_wdata   = ram_rdata;
                    b_next      = $signed(ram_rdata);
                    have_b_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        idx_next   = idx_reg - ADDR_W'(1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    // lower neighbor found, gap to it is the difference
                    cand_next   = alu_res.diff[GAP_W-1:0];
                    have_a_next = 1'b1;
                    idx_next    = idx_reg + ADDR_W'(1);
                    state_next  = ST_INS;
                end
            end
            ST_INS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = x_reg;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = ST_GAP_A;
            end
            ST_GAP_A:
            begin
                if (have_a_reg && alu_res.neg)
                begin
                    gap_next = cand_reg;
                end
                state_next = ST_DIFF_B;
            end
            ST_DIFF_B:
            begin
                cand_next  = alu_res.diff[GAP_W-1:0];
                state_next = ST_GAP_B;
            end
            ST_GAP_B:
            begin
                if (have_b_reg && alu_res.neg)
                begin
                    gap_next = cand_reg;
                end
                state_next = ST_LO;
            end
            ST_LO:
            begin
                if (cnt_reg == CNT_W'(1) || alu_res.neg)
                begin
                    lo_next = x_reg;
                end
                state_next = ST_HI;
            end
            ST_HI:
            begin
                if (cnt_reg == CNT_W'(1) || alu_res.neg)
                begin
                    hi_next = x_reg;
                end
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                span_next  = alu_res.diff[VAL_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // load the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_short_next = span_ok ? gap_reg[VAL_W-1:0] : '0;
                    out_long_next  = span_ok ? span_reg : '0;
                    out_sv_next    = span_ok;
                    out_full_next  = full_reg;
                    out_cnt_next   = cnt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gap_reg       <= GAP_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        idx_reg       <= idx_next;
        cand_reg      <= cand_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        b_reg         <= b_next;
        have_a_reg    <= have_a_next;
        have_b_reg    <= have_b_next;
        full_reg      <= full_next;
        span_reg      <= span_next;
        out_short_reg <= out_short_next;
        out_long_reg  <= out_long_next;
        out_sv_reg    <= out_sv_next;
        out_full_reg  <= out_full_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // result channel
    assign result.valid         = out_valid_reg;
    assign result.shortest_span = out_short_reg;
    assign result.longest_span  = out_long_reg;
    assign result.span_valid    = out_sv_reg;
    assign result.full_error    = out_full_reg;
    assign result.stored_count  = out_cnt_reg;

    // checks
    `BSST_ASSERT_NEXT(a_fire_leaves_idle, clk, rst_n, in_fire, state_reg != ST_IDLE,
        "accepted item did not start processing")
    `BSST_ASSERT_NOW(a_ram_write_state, clk, rst_n, ram_we,
        state_reg == ST_CMP || state_reg == ST_INS, "RAM written outside insert")
    `BSST_ASSERT_NOW(a_lo_le_hi, clk, rst_n, state_reg == ST_IDLE && span_ok,
        lo_reg <= hi_reg, "range bounds out of order")
    `BSST_ASSERT_NOW(a_span_flag, clk, rst_n, result.valid,
        result.span_valid == (result.stored_count >= CNT_W'(2)),
        "span_valid disagrees with stored_count")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded set span tracker.
// A queue of pending values feeds a clocked driver on the item channel and a
// clocked monitor takes results with random stalls. Each accepted value is
// run through a local sorted-set model that predicts the shortest span,
// longest span, flags and count; results are compared field by field in
// order. The capacity register is changed only while the block is idle, over
// a directed section and several random phases that include 0, 64 and 127.
// ---------------------------------------------------------------------------
module tb_top;
    import bsst_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int PHASE_ITEMS  = 193;
    localparam int MAX_PRINTS   = 50;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // how random values of one run are spread
    typedef enum logic [1:0] {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EDGE,
        SPREAD_CLUSTER
    } spread_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    start_new;
    } set_item_t;

    typedef struct packed {
        logic [VAL_W-1:0] shortest;
        logic [VAL_W-1:0] longest;
        logic             span_valid;
        logic             full_error;
        logic [CNT_W-1:0] count;
    } span_report_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bsst_in_if  item ();
    bsst_out_if result ();

    bounded_set_span_tracker #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // model of the set
    logic signed [VAL_W-1:0] set_vals [DEPTH];
    int                      set_size;
    logic [GAP_W-1:0]        min_gap;
    logic [CNT_W-1:0]        capacity_reg;

    set_item_t    pending_items [$];
    span_report_t span_reports_due [$];

    int mismatch_count;
    int cycle_count;
    int send_gap;
    int stall_left;
    bit idle_on;

    always #2 clk = ~clk;

    // distance between two ordered values at 33 bits
    function automatic logic [GAP_W-1:0] span_between(logic signed [VAL_W-1:0] lo,
                                                      logic signed [VAL_W-1:0] hi);
        return {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
    endfunction

    // insert one value into the model set and report the spans after it
    function automatic span_report_t insert_and_measure(logic signed [VAL_W-1:0] x,
                                                        logic fresh);
        span_report_t     r;
        int               limit;
        int               pos;
        logic [GAP_W-1:0] g;
        r     = '0;
        limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        if (fresh)
        begin
            set_size = 0;
            min_gap  = GAP_ONES;
        end
        if (set_size >= limit)
        begin
            r.full_error = 1'b1;
        end
        else
        begin
            pos = 0;
            while (pos < set_size && set_vals[pos] <= x)
                pos++;
            if (pos > 0)
            begin
                g = span_between(set_vals[pos-1], x);
                if (g < min_gap)
                    min_gap = g;
            end
            if (pos < set_size)
            begin
                g = span_between(x, set_vals[pos]);
                if (g < min_gap)
                    min_gap = g;
            end
            for (int i = set_size; i > pos; i--)
                set_vals[i] = set_vals[i-1];
            set_vals[pos] = x;
            set_size++;
        end
        if (set_size >= 2)
        begin
            r.shortest   = min_gap[VAL_W-1:0];
            r.longest    = VAL_W'(span_between(set_vals[0], set_vals[set_size-1]));
            r.span_valid = 1'b1;
        end
        r.count = CNT_W'(set_size);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value(spread_t spread,
                                                           logic signed [VAL_W-1:0] base);
        logic signed [VAL_W-1:0] v;
        case (spread)
            SPREAD_NARROW:
            begin
                v = $urandom_range(0, 48);
                v = v - 24;
            end
            SPREAD_EDGE:
            begin
                case ($urandom_range(0, 6))
                    0: v = VAL_MIN;
                    1: v = VAL_MIN + 1;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = VAL_MAX - 1;
                    default: v = VAL_MAX;
                endcase
            end
            SPREAD_CLUSTER:
                v = base + $urandom_range(0, 1000);
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_item(logic signed [VAL_W-1:0] v, logic fresh);
        pending_items.push_back('{value: v, start_new: fresh});
    endtask

    // wait until every queued value is taken and every result is back
    task automatic drain();
        while (pending_items.size() != 0 || item.valid || span_reports_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] cap);
        drain();
        cfg_we       <= 1'b1;
        cfg_wdata    <= cap;
        capacity_reg  = cap;
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    // runs of values that mostly begin with a fresh set, with a little noise
    task automatic queue_random_phase(int n);
        int                      sent;
        int                      run_len;
        int                      limit;
        spread_t                 spread;
        logic signed [VAL_W-1:0] base;
        logic                    fresh;
        sent = 0;
        while (sent < n)
        begin
            limit   = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
            run_len = $urandom_range(1, limit + 3);
            spread  = spread_t'($urandom_range(0, 3));
            base    = $urandom;
            for (int k = 0; k < run_len && sent < n; k++)
            begin
                if (k == 0)
                    fresh = (sent == 0) ? 1'($urandom_range(0, 1)) : 1'b1;
                else
                    fresh = ($urandom_range(0, 40) == 0);
                queue_item(pick_value(spread, base), fresh);
                sent++;
            end
        end
    endtask

    // item driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        set_item_t next_item;
        logic      load;
        if (!rst_n)
        begin
            item.valid     <= 1'b0;
            item.value     <= '0;
            item.start_new <= 1'b0;
            send_gap        = 0;
        end
        else
        begin
            if (item.valid && item.ready)
                span_reports_due.push_back(insert_and_measure(item.value, item.start_new));
            if (!item.valid || item.ready)
            begin
                load      = 1'b0;
                next_item = '0;
                if (send_gap > 0)
                    send_gap--;
                else if (idle_on && pending_items.size() != 0 && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 5) - 1;
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    load      = 1'b1;
                end
                item.valid <= load;
                if (load)
                begin
                    item.value     <= next_item.value;
                    item.start_new <= next_item.start_new;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        span_report_t want;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (span_reports_due.size() == 0)
                begin
                    report_mismatch("unexpected result count",
                                    VAL_W'(result.stored_count), '0);
                end
                else
                begin
                    want = span_reports_due.pop_front();
                    if (result.shortest_span !== want.shortest)
                        report_mismatch("shortest_span", result.shortest_span, want.shortest);
                    if (result.longest_span !== want.longest)
                        report_mismatch("longest_span", result.longest_span, want.longest);
                    if (result.span_valid !== want.span_valid)
                        report_mismatch("span_valid", VAL_W'(result.span_valid),
                                        VAL_W'(want.span_valid));
                    if (result.full_error !== want.full_error)
                        report_mismatch("full_error", VAL_W'(result.full_error),
                                        VAL_W'(want.full_error));
                    if (result.stored_count !== want.count)
                        report_mismatch("stored_count", VAL_W'(result.stored_count),
                                        VAL_W'(want.count));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left    = $urandom_range(1, 5) - 1;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [CNT_W-1:0] phase_caps [10];
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        item.valid     = 1'b0;
        item.value     = '0;
        item.start_new = 1'b0;
        result.ready   = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        capacity_reg   = CAP_RESET;
        set_size       = 0;
        min_gap        = GAP_ONES;
        phase_caps     = '{7'd2, 7'd127, 7'd0, 7'd64, 7'd1, 7'd17, 7'd65, 7'd100, 7'd5, 7'd0};
        phase_caps[9]  = $urandom_range(0, 127);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // equal values, extremes and full-width spans at reset capacity
        queue_item(0, 1'b1);
        queue_item(0, 1'b0);
        queue_item(VAL_MIN, 1'b1);
        queue_item(VAL_MAX, 1'b0);
        queue_item(0, 1'b0);
        queue_item(-1, 1'b0);
        queue_item(1, 1'b0);
        queue_item(VAL_MAX, 1'b0);
        queue_item(VAL_MIN, 1'b0);
        queue_item(5, 1'b1);
        queue_item(-5, 1'b1);

        // small capacity fills and rejects, start new reopens
        write_capacity(7'd2);
        queue_item(10, 1'b1);
        queue_item(20, 1'b0);
        queue_item(30, 1'b0);
        queue_item(15, 1'b0);
        queue_item(7, 1'b1);

        // zero capacity rejects even right after start new
        write_capacity(7'd0);
        queue_item(3, 1'b1);
        queue_item(4, 1'b0);

        // capacity lowered below the count keeps the set and rejects adds
        write_capacity(7'd64);
        queue_item(100, 1'b1);
        queue_item(-100, 1'b0);
        queue_item(40, 1'b0);
        queue_item(41, 1'b0);
        queue_item(-7, 1'b0);
        write_capacity(7'd3);
        queue_item(0, 1'b0);
        queue_item(VAL_MAX, 1'b0);

        // random phases, the last one without idling
        for (int p = 0; p < 10; p++)
        begin
            write_capacity(phase_caps[p]);
            idle_on = (p == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
            queue_random_phase(PHASE_ITEMS);
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/bsst_pkg.sv
hw/rtl/bsst_in_if.sv
hw/rtl/bsst_out_if.sv
hw/rtl/bsst_ram.sv
hw/rtl/bsst_alu.sv
hw/rtl/bounded_set_span_tracker.sv
bench/tb_top.sv
